/* src/link_failover_hysteresis_fsm_top_assert.svh */
// assertion macros shared by the link failover modules
`ifndef LINK_FAILOVER_HYSTERESIS_FSM_TOP_ASSERT_SVH
`define LINK_FAILOVER_HYSTERESIS_FSM_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LFH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfh assertion failed");

// next-cycle implication, disabled while in reset
`define LFH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfh assertion failed");

`endif

/* src/lfh_pkg.sv */
// types, codes and reset values for the link failover block
package lfh_pkg;

    typedef enum logic [1:0] {
        MODE_STANDBY    = 2'd0,
        MODE_ACTIVATING = 2'd1,
        MODE_ACTIVE     = 2'd2
    } mode_t;

    localparam logic [1:0] ANNOUNCE_NONE = 2'd0;
    localparam logic [1:0] ANNOUNCE_ON   = 2'd1;
    localparam logic [1:0] ANNOUNCE_OFF  = 2'd2;

    localparam logic [1:0] FALLBACK_KEEP    = 2'd0;
    localparam logic [1:0] FALLBACK_ENABLE  = 2'd1;
    localparam logic [1:0] FALLBACK_DISABLE = 2'd2;

    localparam logic [1:0] CFG_DOWN_HOLD   = 2'd0;
    localparam logic [1:0] CFG_UP_HOLD     = 2'd1;
    localparam logic [1:0] CFG_REPORT_INTV = 2'd2;
    localparam logic [1:0] CFG_KEEP_WARM   = 2'd3;

    // one minute in milliseconds
    localparam logic [31:0] HOLD_RESET_MS = 32'(60 * 1000);

    typedef struct packed {
        logic [31:0] down_hold_ms;
        logic [31:0] up_hold_ms;
        logic [31:0] report_interval_ms;
        logic        keep_link_warm;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        primary_up;
        logic        modem_connected;
        logic        modem_alive;
        logic        clock_unset;
    } tick_t;

    typedef struct packed {
        mode_t      mode_now;
        logic       bring_up;
        logic [1:0] announce;
        logic [1:0] fallback_set;
        logic       gate_close;
        logic       link_drop;
        logic       run_recovery;
        logic       clock_sync;
        logic       report_signal;
    } result_t;

endpackage

/* src/lfh_cfg.sv */
// configuration register file for the link failover block
module lfh_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    output lfh_pkg::cfg_t cfg
);
    import lfh_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DOWN_HOLD:   cfg_next.down_hold_ms       = cfg_data;
                CFG_UP_HOLD:     cfg_next.up_hold_ms         = cfg_data;
                CFG_REPORT_INTV: cfg_next.report_interval_ms = cfg_data;
                CFG_KEEP_WARM:   cfg_next.keep_link_warm     = cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.down_hold_ms       <= HOLD_RESET_MS;
            cfg_reg.up_hold_ms         <= HOLD_RESET_MS;
            cfg_reg.report_interval_ms <= HOLD_RESET_MS;
            cfg_reg.keep_link_warm     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/lfh_core.sv */
// failover mode machine with hold timers and report cadence
`include "link_failover_hysteresis_fsm_top_assert.svh"

module lfh_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  lfh_pkg::tick_t   tick,
    input  lfh_pkg::cfg_t    cfg,
    output lfh_pkg::result_t res
);
    import lfh_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [31:0] down_start_reg, down_start_next;
    logic [31:0] up_start_reg, up_start_next;
    logic [31:0] last_report_reg, last_report_next;

    // hold timer starts on first tick seen, zero means not started
    logic [31:0] down_base;
    logic [31:0] up_base;
    logic        down_expired;
    logic        up_expired;
    logic        report_due;

    always_comb
    begin
        down_base    = (down_start_reg == 32'd0) ? tick.now_ms : down_start_reg;
        up_base      = (up_start_reg == 32'd0) ? tick.now_ms : up_start_reg;
        down_expired = (tick.now_ms - down_base) >= cfg.down_hold_ms;
        up_expired   = (tick.now_ms - up_base) >= cfg.up_hold_ms;
        report_due   = (tick.now_ms - last_report_reg) >= cfg.report_interval_ms;
    end

    always_comb
    begin
        mode_next        = mode_reg;
        down_start_next  = down_start_reg;
        up_start_next    = up_start_reg;
        last_report_next = last_report_reg;
        res              = '0;

        unique case (mode_reg)
            MODE_ACTIVATING:
            begin
                res.bring_up = 1'b1;
                if (tick.modem_connected)
                begin
                    mode_next        = MODE_ACTIVE;
                    up_start_next    = 32'd0;
                    last_report_next = 32'd0;
                    res.fallback_set = FALLBACK_ENABLE;
                    res.announce     = ANNOUNCE_ON;
                    res.clock_sync   = tick.clock_unset;
                end
                else
                begin
                    down_start_next = tick.now_ms;
                    mode_next       = MODE_STANDBY;
                end
            end
            MODE_ACTIVE:
            begin
                if (!tick.modem_alive)
                begin
                    res.fallback_set = FALLBACK_DISABLE;
                    mode_next        = MODE_ACTIVATING;
                    last_report_next = 32'd0;
                end
                else
                begin
                    res.run_recovery = 1'b1;
                    if (tick.primary_up)
                    begin
                        up_start_next = up_base;
                        if (up_expired)
                        begin
                            res.announce     = ANNOUNCE_OFF;
                            res.gate_close   = 1'b1;
                            res.fallback_set = FALLBACK_DISABLE;
                            res.link_drop    = !cfg.keep_link_warm;
                            mode_next        = MODE_STANDBY;
                            down_start_next  = 32'd0;
                            up_start_next    = 32'd0;
                        end
                    end
                    else
                    begin
                        up_start_next = 32'd0;
                    end
                    // report may fire on the same tick as a yield
                    if (report_due)
                    begin
                        last_report_next  = tick.now_ms;
                        res.report_signal = 1'b1;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_STANDBY;
                if (!tick.primary_up)
                begin
                    down_start_next = down_base;
                    if (down_expired)
                    begin
                        mode_next = MODE_ACTIVATING;
                    end
                end
                else
                begin
                    down_start_next = 32'd0;
                end
            end
        endcase

        res.mode_now = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_STANDBY;
            down_start_reg  <= 32'd0;
            up_start_reg    <= 32'd0;
            last_report_reg <= 32'd0;
        end
        else if (fire)
        begin
            mode_reg        <= mode_next;
            down_start_reg  <= down_start_next;
            up_start_reg    <= up_start_next;
            last_report_reg <= last_report_next;
        end
    end

    `LFH_ASSERT_NEXT(a_state_holds_when_idle, clk, rst_n, !fire,
        $stable(mode_reg) && $stable(down_start_reg) && $stable(last_report_reg))
    `LFH_ASSERT_NEXT(a_dead_modem_reactivates, clk, rst_n,
        fire && mode_reg == MODE_ACTIVE && !tick.modem_alive,
        mode_reg == MODE_ACTIVATING && last_report_reg == 32'd0)
    `LFH_ASSERT_NEXT(a_report_stamps_time, clk, rst_n, fire && res.report_signal,
        last_report_reg == $past(tick.now_ms))

endmodule

/* src/link_failover_hysteresis_fsm_top.sv */
// top level of the link failover hysteresis block
//
// Link failover controller: each input word is one poll tick (time stamp in ms plus primary
// link, modem connected, modem alive and clock-unset flags) and yields exactly one result
// word with the mode after the tick and the action flags for that tick. A tick is captured
// in an input register, the mode machine and its hold-timer compares evaluate it, and the
// result lands in an output register. One word is accepted every cycle as long as the
// output side keeps taking results; the result word passes through the input register and
// then the output register before it can leave. A stalled result stalls the input only
// once the input register also holds a tick. The limit of one word per cycle is set by the
// update of the mode and timer registers, which each tick reads and writes. Hold timers use
// a start stamp of zero as not started, and all time differences wrap modulo 2^32.
// Configuration registers (down hold, up hold, report interval, keep link warm) must be
// written only while the block holds no words.
`include "link_failover_hysteresis_fsm_top_assert.svh"

module link_failover_hysteresis_fsm_top (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input tick channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] now_ms,
    input  logic        primary_up,
    input  logic        modem_connected,
    input  logic        modem_alive,
    input  logic        clock_unset,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  mode_now,
    output logic        bring_up,
    output logic [1:0]  announce,
    output logic [1:0]  fallback_set,
    output logic        gate_close,
    output logic        link_drop,
    output logic        run_recovery,
    output logic        clock_sync,
    output logic        report_signal
);
    import lfh_pkg::*;

    cfg_t    cfg;
    tick_t   tick_reg;
    logic    in_valid_reg, in_valid_next;
    result_t res;
    result_t result_reg;
    logic    out_valid_reg, out_valid_next;
    logic    fire;
    logic    in_take;

    // the tick in the input register is evaluated once the output register is free
    // or its word is leaving in this cycle
    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            tick_reg.now_ms          <= now_ms;
            tick_reg.primary_up      <= primary_up;
            tick_reg.modem_connected <= modem_connected;
            tick_reg.modem_alive     <= modem_alive;
            tick_reg.clock_unset     <= clock_unset;
        end
        if (fire)
        begin
            result_reg <= res;
        end
    end

    lfh_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lfh_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .tick  (tick_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign out_valid     = out_valid_reg;
    assign mode_now      = 2'(result_reg.mode_now);
    assign bring_up      = result_reg.bring_up;
    assign announce      = result_reg.announce;
    assign fallback_set  = result_reg.fallback_set;
    assign gate_close    = result_reg.gate_close;
    assign link_drop     = result_reg.link_drop;
    assign run_recovery  = result_reg.run_recovery;
    assign clock_sync    = result_reg.clock_sync;
    assign report_signal = result_reg.report_signal;

    // a waiting tick is never dropped, and every evaluation leaves a result word
    `LFH_ASSERT_NEXT(a_waiting_tick_kept, clk, rst_n, in_valid_reg && !fire, in_valid_reg)
    `LFH_ASSERT_NEXT(a_fire_gives_word, clk, rst_n, fire, out_valid_reg)

endmodule
